// ----- src/timer_queue_with_periodic_reload_top_assert.svh -----
// assertion macros used by the timer queue controller rtl
`ifndef TIMER_QUEUE_WITH_PERIODIC_RELOAD_TOP_ASSERT_SVH
`define TIMER_QUEUE_WITH_PERIODIC_RELOAD_TOP_ASSERT_SVH

// same-cycle implication
`define TQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tq_pkg.sv -----
`default_nettype none
package tq_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_W      = $clog2(TIMER_SLOTS);
	localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

	localparam int DIVIDEND_W  = 53;
	localparam int DIVISOR_W   = 36;
	localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

	localparam logic [19:0] NS_PER_MS = 20'd1000000;
	localparam logic [29:0] NS_PER_S  = 30'd1000000000;
	// floor(2^56 / NS_PER_S), seconds estimate from bits 52:24
	localparam logic [26:0] SEC_RECIP = 27'd72057594;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_MODIFY = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_POLL   = 3'd4;

	typedef struct packed {
		logic load;
		logic reject;
		logic add_write;
		logic del;
		logic mod_write;
		logic scan;
		logic fire;
		logic mul;
		logic sum;
		logic div1_start;
		logic sec_rnd;
		logic sec_est;
		logic sec_rem;
		logic store;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       slot_ok;
		logic       slot_busy;
		logic       scan_done;
		logic       found;
		logic       best_per;
		logic       div_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- src/tq_div.sv -----
`default_nettype none
module tq_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [tq_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [tq_pkg::DIVISOR_W-1:0]  divisor,
	output logic                                busy,
	output logic [tq_pkg::DIVISOR_W-1:0]       rem
);

	logic                            busy_q;
	logic [tq_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [tq_pkg::DIVIDEND_W-1:0]   quo_q;
	logic [tq_pkg::DIVISOR_W-1:0]    rem_q;
	logic [tq_pkg::DIVISOR_W-1:0]    dvs_q;
	logic [tq_pkg::DIVISOR_W:0]      shifted;
	logic [tq_pkg::DIVISOR_W:0]      diff;

	assign shifted = {rem_q, quo_q[tq_pkg::DIVIDEND_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= tq_pkg::DIV_CNT_W'(tq_pkg::DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - tq_pkg::DIV_CNT_W'(1);
			if (cnt_q == tq_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[tq_pkg::DIVISOR_W]) begin
				rem_q <= diff[tq_pkg::DIVISOR_W-1:0];
				quo_q <= {quo_q[tq_pkg::DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[tq_pkg::DIVISOR_W-1:0];
				quo_q <= {quo_q[tq_pkg::DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ----- src/tq_dp.sv -----
`default_nettype none
module tq_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_wdata,
	input  wire logic [2:0]        command,
	input  wire logic [3:0]        slot_index,
	input  wire logic [31:0]       interval_ms,
	input  wire logic [15:0]       round_ms,
	input  wire logic              periodic,
	input  wire logic [31:0]       user_tag,
	input  wire logic [31:0]       now_seconds,
	input  wire logic [29:0]       now_nanoseconds,
	output logic                   status,
	output logic                   fired,
	output logic [3:0]             fired_slot,
	output logic [31:0]            fired_tag,
	output logic                   slot_pending,
	input  wire tq_pkg::ctrl_cmd_t cmd,
	output tq_pkg::dp_stat_t       stat
);

	localparam int N  = tq_pkg::TIMER_SLOTS;
	localparam int SW = tq_pkg::SLOT_W;
	localparam int CW = tq_pkg::CNT_W;

	logic [15:0] dflt_prec_q;
	logic [2:0]  op_q;
	logic [3:0]  slot_q;
	logic [31:0] int_q;
	logic [15:0] prec_q;
	logic        per_q;
	logic [31:0] tag_q;
	logic [31:0] now_s_q;
	logic [29:0] now_ns_q;

	logic [N-1:0] pending_q;
	logic [N-1:0] periodic_q;

	logic [31:0] int_mem   [N];
	logic [15:0] prec_mem  [N];
	logic [31:0] tag_mem   [N];
	logic [33:0] exps_mem  [N];
	logic [29:0] expns_mem [N];

	logic [31:0] int_rd_q;
	logic [15:0] prec_rd_q;
	logic [31:0] tag_rd_q;
	logic [33:0] exps_rd_q;
	logic [29:0] expns_rd_q;

	logic [CW-1:0] cnt_q;
	logic          vld_s1;
	logic [SW-1:0] idx_s1;
	logic          found_q;
	logic [SW-1:0] best_q;
	logic [33:0]   best_s_q;
	logic [29:0]   best_ns_q;

	logic          rej_q;
	logic          fired_q;
	logic [31:0]   ftag_q;

	logic [51:0]   mul_s1;
	logic [35:0]   step_s1;
	logic [52:0]   dividend_q;
	logic [52:0]   rnd_q;
	logic [23:0]   qest_q;
	logic [30:0]   nsrem_q;

	logic          status_q;
	logic          fired_out_q;
	logic [3:0]    fslot_q;
	logic [31:0]   ftag_out_q;
	logic          spend_q;

	logic [SW-1:0] slot_idx;
	logic          slot_ok;
	logic          is_poll;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] arm_idx;
	logic [15:0]   add_prec;
	logic [31:0]   arm_int;
	logic [15:0]   arm_prec;
	logic [15:0]   prec_eff;
	logic          due;
	logic          earlier;
	logic          take;
	logic          div_busy;
	logic [35:0]   div_rem;
	logic [55:0]   est_prod;
	logic [53:0]   sec_prod;
	logic          sec_carry;
	logic          spend_val;

	assign slot_idx = SW'(slot_q);
	assign slot_ok  = 32'(slot_q) < 32'(N);
	assign is_poll  = op_q == tq_pkg::OP_POLL;
	assign rd_addr  = cmd.scan ? cnt_q[SW-1:0] : (is_poll ? best_q : slot_idx);
	assign arm_idx  = is_poll ? best_q : slot_idx;
	assign add_prec = (prec_q != 16'd0) ? prec_q : dflt_prec_q;
	assign arm_int  = is_poll ? int_rd_q : int_q;
	assign arm_prec = (op_q == tq_pkg::OP_ADD) ? add_prec : prec_rd_q;
	assign prec_eff = (arm_prec == 16'd0) ? 16'd1 : arm_prec;

	// scan compare on the word read in the cycle before
	assign due = (exps_rd_q < 34'(now_s_q)) ||
		((exps_rd_q == 34'(now_s_q)) && (expns_rd_q <= now_ns_q));
	assign earlier = (exps_rd_q < best_s_q) ||
		((exps_rd_q == best_s_q) && (expns_rd_q < best_ns_q));
	assign take = vld_s1 && pending_q[idx_s1] && due && (!found_q || earlier);

	// seconds estimate is exact or one low, fixed by one compare at store
	assign est_prod  = rnd_q[52:24] * tq_pkg::SEC_RECIP;
	assign sec_prod  = qest_q * tq_pkg::NS_PER_S;
	assign sec_carry = nsrem_q >= 31'(tq_pkg::NS_PER_S);

	assign spend_val = is_poll ? (fired_q & pending_q[best_q]) : (slot_ok & pending_q[slot_idx]);

	tq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div1_start),
		.dividend (dividend_q),
		.divisor  (step_s1),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_prec_q <= 16'd1;
		end else if (cfg_we) begin
			dflt_prec_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= command;
			slot_q   <= slot_index;
			int_q    <= interval_ms;
			prec_q   <= round_ms;
			per_q    <= periodic;
			tag_q    <= user_tag;
			now_s_q  <= now_seconds;
			now_ns_q <= now_nanoseconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			periodic_q <= '0;
		end else begin
			if (cmd.add_write) begin
				periodic_q[slot_idx] <= per_q;
			end
			if (cmd.del) begin
				pending_q[slot_idx] <= 1'b0;
			end
			if (cmd.fire) begin
				pending_q[best_q] <= 1'b0;
			end
			if (cmd.store) begin
				pending_q[arm_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_write || cmd.mod_write) begin
			int_mem[slot_idx] <= int_q;
		end
		if (cmd.add_write) begin
			prec_mem[slot_idx] <= add_prec;
			tag_mem[slot_idx]  <= tag_q;
		end
		if (cmd.store) begin
			exps_mem[arm_idx]  <= 34'(now_s_q) + 34'(qest_q) + 34'(sec_carry);
			expns_mem[arm_idx] <= sec_carry ? 30'(nsrem_q - 31'(tq_pkg::NS_PER_S))
				: nsrem_q[29:0];
		end
		int_rd_q   <= int_mem[rd_addr];
		prec_rd_q  <= prec_mem[rd_addr];
		tag_rd_q   <= tag_mem[rd_addr];
		exps_rd_q  <= exps_mem[rd_addr];
		expns_rd_q <= expns_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			rej_q   <= 1'b0;
			fired_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			rej_q   <= 1'b0;
			fired_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan && (cnt_q < CW'(N));
			if (cmd.scan && (cnt_q < CW'(N))) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.reject) begin
				rej_q <= 1'b1;
			end
			if (cmd.fire) begin
				fired_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[SW-1:0];
		if (take) begin
			best_q    <= idx_s1;
			best_s_q  <= exps_rd_q;
			best_ns_q <= expns_rd_q;
		end
		if (cmd.fire) begin
			ftag_q <= tag_rd_q;
		end
		if (cmd.mul) begin
			mul_s1  <= arm_int * tq_pkg::NS_PER_MS;
			step_s1 <= prec_eff * tq_pkg::NS_PER_MS;
		end
		if (cmd.sum) begin
			dividend_q <= 53'(now_ns_q) + 53'(mul_s1) + 53'(step_s1) - 53'd1;
		end
		if (cmd.sec_rnd) begin
			rnd_q <= dividend_q - 53'(div_rem);
		end
		if (cmd.sec_est) begin
			qest_q <= est_prod[55:32];
		end
		if (cmd.sec_rem) begin
			nsrem_q <= 31'(rnd_q - sec_prod[52:0]);
		end
		if (cmd.finish) begin
			status_q    <= rej_q;
			fired_out_q <= fired_q;
			fslot_q     <= fired_q ? 4'(best_q) : 4'd0;
			ftag_out_q  <= fired_q ? ftag_q : 32'd0;
			spend_q     <= spend_val;
		end
	end

	assign status       = status_q;
	assign fired        = fired_out_q;
	assign fired_slot   = fslot_q;
	assign fired_tag    = ftag_out_q;
	assign slot_pending = spend_q;

	assign stat.op        = op_q;
	assign stat.slot_ok   = slot_ok;
	assign stat.slot_busy = pending_q[slot_idx];
	assign stat.scan_done = (cnt_q == CW'(N)) && !vld_s1;
	assign stat.found     = found_q;
	assign stat.best_per  = periodic_q[best_q];
	assign stat.div_busy  = div_busy;

endmodule
`default_nettype wire

// ----- src/tq_ctrl.sv -----
`default_nettype none
`include "timer_queue_with_periodic_reload_top_assert.svh"
module tq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output tq_pkg::ctrl_cmd_t     cmd,
	input  wire tq_pkg::dp_stat_t stat
);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_DECODE = 14'b00000000000010,
		S_SCAN   = 14'b00000000000100,
		S_FETCH  = 14'b00000000001000,
		S_PICK   = 14'b00000000010000,
		S_MUL    = 14'b00000000100000,
		S_SUM    = 14'b00000001000000,
		S_D1GO   = 14'b00000010000000,
		S_D1WAIT = 14'b00000100000000,
		S_SEC1   = 14'b00001000000000,
		S_SEC2   = 14'b00010000000000,
		S_SEC3   = 14'b00100000000000,
		S_STORE  = 14'b01000000000000,
		S_FINISH = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				if (stat.op == tq_pkg::OP_POLL) begin
					state_d = S_SCAN;
				end else if (stat.slot_ok) begin
					priority if (stat.op == tq_pkg::OP_ADD) begin
						if (stat.slot_busy) begin
							cmd.reject = 1'b1;
						end else begin
							cmd.add_write = 1'b1;
							state_d       = S_MUL;
						end
					end else if (stat.op == tq_pkg::OP_DELETE) begin
						cmd.del = 1'b1;
					end else if (stat.op == tq_pkg::OP_MODIFY) begin
						cmd.mod_write = 1'b1;
						state_d       = S_MUL;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					cmd.scan = 1'b0;
					state_d  = stat.found ? S_FETCH : S_FINISH;
				end
			end
			S_FETCH: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.fire = 1'b1;
				state_d  = stat.best_per ? S_MUL : S_FINISH;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_D1GO;
			end
			S_D1GO: begin
				cmd.div1_start = 1'b1;
				state_d        = S_D1WAIT;
			end
			S_D1WAIT: begin
				if (!stat.div_busy) begin
					state_d = S_SEC1;
				end
			end
			S_SEC1: begin
				cmd.sec_rnd = 1'b1;
				state_d     = S_SEC2;
			end
			S_SEC2: begin
				cmd.sec_est = 1'b1;
				state_d     = S_SEC3;
			end
			S_SEC3: begin
				cmd.sec_rem = 1'b1;
				state_d     = S_STORE;
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`TQ_ASSERT_NXT(a_accept_decode, in_valid && !in_stall, state_q == S_DECODE, "accept without decode")
	`TQ_ASSERT_NXT(a_div_chain, state_q == S_D1WAIT && !stat.div_busy, state_q == S_SEC1, "seconds split skipped")
	`TQ_ASSERT_NXT(a_finish_out, cmd.finish, out_valid_q && state_q == S_IDLE, "result word lost")

endmodule
`default_nettype wire

// ----- src/timer_queue_with_periodic_reload_top.sv -----
// channel | handshake                 | contents
// in      | in_valid / in_stall       | command word: op, slot, interval, precision, tag, time
// out     | out_valid / out_stall     | result word: status, fired, slot, tag, pending mark
// cfg     | cfg_we / cfg_wdata        | default precision in ms, reset value 1
// one word at a time; query, delete and refused add go from decode straight to finish
// poll: the one-slot-a-cycle scan over all TIMER_SLOTS, then fetch and fire states on a fire
// arming (add, modify, periodic fire): mostly the 53-step serial divide by the step
// arst_n clears marks and control; slot stores hold until written, no clearing pass
// a stalled result word holds in the output register; next word waits in the finish state
`default_nettype none
module timer_queue_with_periodic_reload_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [3:0]  slot_index,
	input  wire logic [31:0] interval_ms,
	input  wire logic [15:0] round_ms,
	input  wire logic        periodic,
	input  wire logic [31:0] user_tag,
	input  wire logic [31:0] now_seconds,
	input  wire logic [29:0] now_nanoseconds,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic             fired,
	output logic [3:0]       fired_slot,
	output logic [31:0]      fired_tag,
	output logic             slot_pending
);

	tq_pkg::ctrl_cmd_t cmd;
	tq_pkg::dp_stat_t  stat;

	tq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	tq_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.command         (command),
		.slot_index      (slot_index),
		.interval_ms     (interval_ms),
		.round_ms        (round_ms),
		.periodic        (periodic),
		.user_tag        (user_tag),
		.now_seconds     (now_seconds),
		.now_nanoseconds (now_nanoseconds),
		.status          (status),
		.fired           (fired),
		.fired_slot      (fired_slot),
		.fired_tag       (fired_tag),
		.slot_pending    (slot_pending),
		.cmd             (cmd),
		.stat            (stat)
	);

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
module tb;

	localparam logic [2:0] OP_BAD_LO = 3'd5;
	localparam logic [2:0] OP_BAD_HI = 3'd7;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  slot;
		logic [31:0] iv;
		logic [15:0] pr;
		logic        per;
		logic [31:0] tag;
		logic [31:0] s;
		logic [29:0] ns;
	} tq_word_t;

	typedef struct packed {
		logic        status;
		logic        fired;
		logic [3:0]  fslot;
		logic [31:0] ftag;
		logic        spend;
	} tq_result_t;

	typedef struct packed {
		tq_word_t   w;
		logic       known;
		tq_result_t r;
	} tq_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] command = 0;
	logic [3:0] slot_index = 0;
	logic [31:0] interval_ms = 0;
	logic [15:0] round_ms = 0;
	logic periodic = 0;
	logic [31:0] user_tag = 0;
	logic [31:0] now_seconds = 0;
	logic [29:0] now_nanoseconds = 0;
	logic out_valid;
	logic out_stall = 0;
	logic status, fired, slot_pending;
	logic [3:0] fired_slot;
	logic [31:0] fired_tag;

	timer_queue_with_periodic_reload_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.slot_index(slot_index), .interval_ms(interval_ms), .round_ms(round_ms),
		.periodic(periodic), .user_tag(user_tag), .now_seconds(now_seconds),
		.now_nanoseconds(now_nanoseconds), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .fired(fired), .fired_slot(fired_slot), .fired_tag(fired_tag),
		.slot_pending(slot_pending)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// timer state mirror
	logic [15:0] dflt_prec = 16'd1;
	logic        pend_m [16];
	logic        per_m [16];
	logic        added_m [16];
	logic [31:0] intv_m [16];
	logic [15:0] prec_m [16];
	logic [31:0] tag_m [16];
	logic [33:0] exp_s [16];
	logic [29:0] exp_ns [16];

	tq_result_t result_fifo[$];
	int n_items = 0, n_fires = 0, n_refused = 0, n_results = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	initial begin
		for (int i = 0; i < 16; i++) begin
			pend_m[i] = 0; per_m[i] = 0; added_m[i] = 0; intv_m[i] = 0;
			prec_m[i] = 0; tag_m[i] = 0; exp_s[i] = 0; exp_ns[i] = 0;
		end
	end

	function automatic void arm_timer(int s, logic [63:0] t_s, logic [63:0] t_ns);
		logic [63:0] p, step, ns;
		p = {48'd0, prec_m[s]};
		if (p == 0) p = 1;
		step = p * 64'd1000000;
		ns = t_ns + {32'd0, intv_m[s]} * 64'd1000000;
		ns = (ns + step - 1) / step * step;
		exp_s[s] = 34'(t_s + ns / 64'd1000000000);
		exp_ns[s] = 30'(ns % 64'd1000000000);
		pend_m[s] = 1;
	endfunction

	function automatic tq_result_t timer_model(tq_word_t w);
		tq_result_t r;
		int best;
		bit found, due, earlier;
		logic [33:0] ts;
		r = '0;
		ts = {2'b0, w.s};
		if (w.cmd == tq_pkg::OP_POLL) begin
			best = 0;
			found = 0;
			for (int i = 0; i < 16; i++) begin
				if (pend_m[i]) begin
					due = exp_s[i] < ts || (exp_s[i] == ts && exp_ns[i] <= w.ns);
					earlier = exp_s[i] != exp_s[best] ? exp_s[i] < exp_s[best]
						: exp_ns[i] < exp_ns[best];
					if (due && (!found || earlier)) begin
						best = i;
						found = 1;
					end
				end
			end
			if (found) begin
				pend_m[best] = 0;
				if (per_m[best]) arm_timer(best, {32'd0, w.s}, {34'd0, w.ns});
				r.fired = 1;
				r.fslot = 4'(best);
				r.ftag = tag_m[best];
				r.spend = pend_m[best];
			end
		end else begin
			case (w.cmd)
				tq_pkg::OP_ADD: begin
					if (pend_m[w.slot]) begin
						r.status = 1;
					end else begin
						intv_m[w.slot] = w.iv;
						prec_m[w.slot] = w.pr != 0 ? w.pr : dflt_prec;
						tag_m[w.slot] = w.tag;
						per_m[w.slot] = w.per;
						added_m[w.slot] = 1;
						arm_timer(w.slot, {32'd0, w.s}, {34'd0, w.ns});
					end
				end
				tq_pkg::OP_DELETE: pend_m[w.slot] = 0;
				tq_pkg::OP_MODIFY: begin
					intv_m[w.slot] = w.iv;
					arm_timer(w.slot, {32'd0, w.s}, {34'd0, w.ns});
				end
				default: ;
			endcase
			r.spend = pend_m[w.slot];
		end
		return r;
	endfunction

	// caller is at a rising edge
	task automatic send_word(tq_word_t w, logic known, tq_result_t r);
		tq_result_t p;
		in_valid <= 1;
		command <= w.cmd;
		slot_index <= w.slot;
		interval_ms <= w.iv;
		round_ms <= w.pr;
		periodic <= w.per;
		user_tag <= w.tag;
		now_seconds <= w.s;
		now_nanoseconds <= w.ns;
		do @(posedge clk); while (in_stall);
		p = timer_model(w);
		result_fifo.push_back(known ? r : p);
		n_items++;
		n_fires += p.fired;
		n_refused += p.status;
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
				: $urandom_range(1, 15);
			in_valid <= 0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_default(logic [15:0] v);
		in_valid <= 0;
		while (result_fifo.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		dflt_prec = v;
	endtask

	// receiver stall pattern
	int stall_mode = 0, stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_left <= $urandom_range(5, 60);
			end else begin
				stall_left <= stall_left - 1;
			end
			out_stall <= stall_mode == 1 ? 1'($urandom_range(0, 1))
				: stall_mode == 2 ? ($urandom_range(0, 7) != 0) : 1'b0;
		end
	end

	always @(posedge clk) begin
		tq_result_t e, a;
		if (arst_n && out_valid && !out_stall) begin
			a = '{status, fired, fired_slot, fired_tag, slot_pending};
			n_results++;
			if (result_fifo.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", a);
			end else begin
				e = result_fifo.pop_front();
				if (a !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch word %0d: exp st%b f%b s%0d t%h p%b %s",
							n_results, e.status, e.fired, e.fslot, e.ftag, e.spend,
							$sformatf("got st%b f%b s%0d t%h p%b",
							a.status, a.fired, a.fslot, a.ftag, a.spend));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired, %0d words outstanding", result_fifo.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	tq_row_t dir_tbl [18] = '{
		'{'{tq_pkg::OP_QUERY, 4'd0, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0, 30'd0}, 1'b1,
			'{0, 0, 0, 0, 0}},
		'{'{tq_pkg::OP_ADD, 4'd0, 32'd0, 16'd0, 1'b0, 32'hFFFFFFFF, 32'd0, 30'd0}, 1'b1,
			'{0, 0, 0, 0, 1}},
		'{'{tq_pkg::OP_ADD, 4'd0, 32'd9, 16'd2, 1'b1, 32'd1, 32'd0, 30'd0}, 1'b1,
			'{1, 0, 0, 0, 1}},
		'{'{tq_pkg::OP_POLL, 4'd0, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0, 30'd0}, 1'b1,
			'{0, 1, 0, 32'hFFFFFFFF, 0}},
		'{'{tq_pkg::OP_POLL, 4'd0, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0, 30'd0}, 1'b1,
			'{0, 0, 0, 0, 0}},
		'{'{tq_pkg::OP_ADD, 4'd15, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 32'd0, 32'hFFFFFFFF,
			30'h3FFFFFFF}, 1'b0, '0},
		'{'{tq_pkg::OP_ADD, 4'd3, 32'd5, 16'd3, 1'b1, 32'hA5A5A5A5, 32'd10, 30'd999999999},
			1'b0, '0},
		'{'{tq_pkg::OP_ADD, 4'd4, 32'd5, 16'd3, 1'b0, 32'h5A5A5A5A, 32'd10, 30'd999999999},
			1'b0, '0},
		'{'{tq_pkg::OP_POLL, 4'd0, 32'd0, 16'd0, 1'b0, 32'd0, 32'd11, 30'd10000000}, 1'b0, '0},
		'{'{tq_pkg::OP_POLL, 4'd0, 32'd0, 16'd0, 1'b0, 32'd0, 32'd11, 30'd10000000}, 1'b0, '0},
		'{'{tq_pkg::OP_DELETE, 4'd4, 32'd0, 16'd0, 1'b0, 32'd0, 32'd11, 30'd0}, 1'b1,
			'{0, 0, 0, 0, 0}},
		'{'{tq_pkg::OP_MODIFY, 4'd4, 32'd1, 16'd0, 1'b0, 32'd0, 32'd20, 30'd0}, 1'b0, '0},
		'{'{tq_pkg::OP_DELETE, 4'd3, 32'd0, 16'd0, 1'b0, 32'd0, 32'd20, 30'd0}, 1'b1,
			'{0, 0, 0, 0, 0}},
		'{'{tq_pkg::OP_DELETE, 4'd15, 32'd0, 16'd0, 1'b0, 32'd0, 32'd20, 30'd0}, 1'b1,
			'{0, 0, 0, 0, 0}},
		'{'{OP_BAD_LO, 4'd4, 32'd0, 16'd0, 1'b0, 32'd0, 32'd20, 30'd0}, 1'b0, '0},
		'{'{OP_BAD_HI, 4'd0, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF,
			30'h3FFFFFFF}, 1'b0, '0},
		'{'{tq_pkg::OP_QUERY, 4'd4, 32'd0, 16'd0, 1'b0, 32'd0, 32'd20, 30'd0}, 1'b0, '0},
		'{'{tq_pkg::OP_POLL, 4'd0, 32'd0, 16'd0, 1'b0, 32'd0, 32'hFFFFFFFF, 30'h3FFFFFFF},
			1'b0, '0}
	};

	logic [15:0] phase_prec [6] = '{16'd1, 16'hFFFF, 16'd0, 16'd7, 16'd2, 16'd1};

	initial begin
		tq_word_t w;
		logic [63:0] t_ns;
		logic [31:0] t_s;
		int pick;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_tbl[i]) send_word(dir_tbl[i].w, dir_tbl[i].known, dir_tbl[i].r);
		t_s = 32'd100;
		t_ns = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_default(ph == 3 ? 16'($urandom_range(1, 65535)) : phase_prec[ph]);
			for (int k = 0; k < 300; k++) begin
				t_ns += $urandom_range(0, 8) * 64'd1000000 + $urandom_range(0, 999999);
				if (t_ns >= 64'd1000000000) begin
					t_ns -= 64'd1000000000;
					t_s++;
				end
				w.slot = 4'($urandom_range(0, 15));
				w.iv = $urandom_range(0, 40);
				w.pr = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 6));
				w.per = 1'($urandom_range(0, 1));
				w.tag = $urandom;
				w.s = t_s;
				w.ns = 30'(t_ns);
				pick = $urandom_range(0, 99);
				w.cmd = pick < 30 ? tq_pkg::OP_ADD : pick < 62 ? tq_pkg::OP_POLL
					: pick < 72 ? tq_pkg::OP_DELETE : pick < 84 ? tq_pkg::OP_MODIFY
					: pick < 95 ? tq_pkg::OP_QUERY
					: 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
				if ($urandom_range(0, 19) == 0) begin
					w.iv = $urandom;
					w.pr = 16'($urandom);
					w.ns = 30'($urandom);
					if ($urandom_range(0, 1)) w.s = $urandom;
				end
				if (w.cmd == tq_pkg::OP_MODIFY && !added_m[w.slot]) w.cmd = tq_pkg::OP_ADD;
				send_word(w, 1'b0, '0);
			end
		end
		in_valid <= 0;
		while (result_fifo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d command words, %0d timer firings, %0d refused adds, 6 precision settings",
			n_items, n_fires, n_refused);
		$display("%0d result words checked, %0d mismatches", n_results, mismatches);
		if (mismatches == 0 && result_fifo.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
